/* hw/rtl/rsqs_pkg.sv */
// Shared types, command codes, Newton constants and the seed ROM for the
// fixed-point reciprocal square root / square root pipeline. No dependencies.
`default_nettype none

package rsqs_pkg;

   localparam int STAGE_COUNT = 10;
   localparam int SEED_DEPTH  = 96;

   localparam logic [1:0] CMD_RSQRT32 = 2'd0;
   localparam logic [1:0] CMD_SQRT32  = 2'd1;
   localparam logic [1:0] CMD_RSQRT64 = 2'd2;
   localparam logic [1:0] CMD_SQRT64  = 2'd3;

   // 3.0 in Q15 (32-bit path) and Q47 (64-bit path)
   localparam logic [63:0] THREE_Q15 = 64'h0000_0000_0001_8000;
   localparam logic [63:0] THREE_Q47 = 64'h0001_8000_0000_0000;

   // reciprocal root of zero
   localparam logic [63:0] RSQRT32_ZERO = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] RSQRT64_ZERO = 64'hFFFF_FFFF_FFFF_FFFE;

   typedef logic [7:0] seed_rom_type [SEED_DEPTH];

   // data that rides along with every beat; command[1] selects the 64-bit path
   typedef struct packed {
      logic [1:0]  command;
      logic        zero;
      logic [63:0] operand;
   } tag_type;

   // entry i: largest n with n*n*(10*i + 323) <= 83886080, minus 256
   function automatic seed_rom_type build_seed_rom();
      seed_rom_type rom;
      longint       lo;
      longint       hi;
      longint       mid;
      longint       c;
      for (int i = 0; i < SEED_DEPTH; i++) begin
         c  = 10 * longint'(i) + 323;
         lo = 256;
         hi = 511;
         while (lo < hi) begin
            mid = (lo + hi + 1) >>> 1;
            if (mid * mid * c <= 64'sd83886080) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         rom[i] = 8'(lo - 256);
      end
      return rom;
   endfunction

   localparam seed_rom_type SEED_ROM = build_seed_rom();

endpackage

`default_nettype wire

/* hw/rtl/rsqs_front.sv */
// Front end: input register, even leading-zero count, normalize and seed lookup.
// Uses rsqs_pkg (tag_type, SEED_ROM).
`default_nettype none

module rsqs_front (
   input  wire logic                   clock,
   input  wire logic [2:0]             stage_en,
   input  wire logic [1:0]             req_command,
   input  wire logic [63:0]            req_operand_value,
   output rsqs_pkg::tag_type           tag_out,
   output logic [4:0]                  half_out,
   output logic [8:0]                  seed_out,
   output logic [46:0]                 dnorm_out
);

   // leading zeros rounded down to even; value only matters for nonzero input
   function automatic logic [5:0] even_lz(input logic [63:0] val);
      logic [5:0] cnt;
      cnt = '0;
      for (int k = 0; k < 32; k++) begin
         if (val[2*k +: 2] != 2'b00) begin
            cnt = 6'(62 - 2 * k);
         end
      end
      return cnt;
   endfunction

   logic [1:0]        cmd0_ff;
   logic [63:0]       op0_ff;
   logic [63:0]       n0;
   rsqs_pkg::tag_type tag1_in, tag1_ff;
   logic [63:0]       n1_ff;
   logic [5:0]        s1_in, s1_ff;
   logic [63:0]       d1;
   logic [6:0]        idx1;
   logic [8:0]        seed2_in, seed2_ff;
   logic [46:0]       b2_in, b2_ff;
   rsqs_pkg::tag_type tag2_ff;
   logic [4:0]        half2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cmd0_ff <= req_command;
         op0_ff  <= req_operand_value;
      end
   end

   // 32-bit commands sit in the upper word so one 64-bit normalizer serves both
   always_comb begin
      n0 = cmd0_ff[1] ? op0_ff : {op0_ff[31:0], 32'h0};
      tag1_in.command = cmd0_ff;
      tag1_in.zero    = (n0 == 64'h0);
      tag1_in.operand = op0_ff;
      s1_in = even_lz(n0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         tag1_ff <= tag1_in;
         n1_ff   <= n0;
         s1_ff   <= s1_in;
      end
   end

   always_comb begin
      d1 = n1_ff << s1_ff;
      // top seven bits are 32..127 once normalized; zero input is parked at entry 0
      idx1 = tag1_ff.zero ? 7'd0 : 7'(d1[63:57] - 7'd32);
      seed2_in = {1'b1, rsqs_pkg::SEED_ROM[idx1]};
      b2_in = tag1_ff.command[1] ? d1[63:17] : {32'h0, d1[63:49]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tag2_ff  <= tag1_ff;
         half2_ff <= s1_ff[5:1];
         seed2_ff <= seed2_in;
         b2_ff    <= b2_in;
      end
   end

   assign tag_out   = tag2_ff;
   assign half_out  = half2_ff;
   assign seed_out  = seed2_ff;
   assign dnorm_out = b2_ff;

endmodule

`default_nettype wire

/* hw/rtl/rsqs_newton.sv */
// One Newton step x' = x * (3 - d*x^2) / 2 in wrapping fixed point, four stages.
// Uses rsqs_pkg (tag_type, Newton constants).
`default_nettype none

module rsqs_newton (
   input  wire logic                   clock,
   input  wire logic [3:0]             stage_en,
   input  wire rsqs_pkg::tag_type      tag_in,
   input  wire logic [4:0]             half_in,
   input  wire logic [8:0]             seed_in,
   input  wire logic [46:0]            dnorm_in,
   output rsqs_pkg::tag_type           tag_out,
   output logic [4:0]                  half_out,
   output logic [79:0]                 prod_out
);

   rsqs_pkg::tag_type tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   logic [4:0]        half3_ff, half4_ff, half5_ff, half6_ff;
   logic [8:0]        x3_ff, x4_ff;
   logic [17:0]       sq3_ff;
   logic [46:0]       b3_ff;
   logic [41:0]       pl4_in, pl4_ff;
   logic [40:0]       ph4_in, ph4_ff;
   logic [63:0]       ab4;
   logic [63:0]       a5_in, a5_ff;
   logic [63:0]       diff4;
   logic [15:0]       bx5_ff;
   logic [79:0]       prod6_in, prod6_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         tag3_ff  <= tag_in;
         half3_ff <= half_in;
         x3_ff    <= seed_in;
         sq3_ff   <= 18'(seed_in) * 18'(seed_in);
         b3_ff    <= dnorm_in;
      end
   end

   // x^2 * d split into two partial products
   always_comb begin
      pl4_in = 42'(sq3_ff) * 42'(b3_ff[23:0]);
      ph4_in = 41'(sq3_ff) * 41'(b3_ff[46:24]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         tag4_ff  <= tag3_ff;
         half4_ff <= half3_ff;
         x4_ff    <= x3_ff;
         pl4_ff   <= pl4_in;
         ph4_ff   <= ph4_in;
      end
   end

   always_comb begin
      ab4   = 64'(pl4_ff) + 64'({ph4_ff, 24'h0});
      diff4 = (tag4_ff.command[1] ? rsqs_pkg::THREE_Q47 : rsqs_pkg::THREE_Q15)
              - {16'h0, ab4[63:16]};
      // 32-bit path wraps at 32 bits
      a5_in = tag4_ff.command[1] ? diff4 : {32'h0, diff4[31:0]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tag5_ff  <= tag4_ff;
         half5_ff <= half4_ff;
         a5_ff    <= a5_in;
         bx5_ff   <= {x4_ff, 7'h0};
      end
   end

   assign prod6_in = {16'h0, a5_ff} * {64'h0, bx5_ff};

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         tag6_ff  <= tag5_ff;
         half6_ff <= half5_ff;
         prod6_ff <= prod6_in;
      end
   end

   assign tag_out  = tag6_ff;
   assign half_out = half6_ff;
   assign prod_out = prod6_ff;

endmodule

`default_nettype wire

/* hw/rtl/rsqs_back.sv */
// Back end: denormalize, zero override, root = rsqrt * operand, result select.
// Uses rsqs_pkg (tag_type, command codes, zero constants).
`default_nettype none

module rsqs_back (
   input  wire logic                   clock,
   input  wire logic [2:0]             stage_en,
   input  wire rsqs_pkg::tag_type      tag_in,
   input  wire logic [4:0]             half_in,
   input  wire logic [79:0]            prod_in,
   output logic [63:0]                 result_out
);

   logic [4:0]        sh6;
   logic [79:0]       src6;
   logic [79:0]       shifted6;
   logic [63:0]       r7_in, r7_ff;
   rsqs_pkg::tag_type tag7_ff;
   logic [63:0]       vm7;
   logic [63:0]       p00_in, p01_in, p10_in, p11_in;
   logic [63:0]       p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0]       r8_ff;
   logic [1:0]        cmd8_ff;
   logic [127:0]      full8;
   logic [63:0]       result9_in, result9_ff;

   always_comb begin
      if (tag_in.command[1]) begin
         sh6  = 5'(5'd31 - half_in);
         src6 = prod_in;
      end else begin
         sh6  = 5'(5'd15 - half_in);
         src6 = {48'h0, prod_in[31:0]};
      end
      shifted6 = src6 >> sh6;
      if (tag_in.zero) begin
         r7_in = tag_in.command[1] ? rsqs_pkg::RSQRT64_ZERO : rsqs_pkg::RSQRT32_ZERO;
      end else begin
         r7_in = shifted6[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         tag7_ff <= tag_in;
         r7_ff   <= r7_in;
      end
   end

   // four 32x32 partial products of rsqrt * operand
   always_comb begin
      vm7 = tag7_ff.command[1] ? tag7_ff.operand : {32'h0, tag7_ff.operand[31:0]};
      p00_in = 64'(r7_ff[31:0])  * 64'(vm7[31:0]);
      p01_in = 64'(r7_ff[31:0])  * 64'(vm7[63:32]);
      p10_in = 64'(r7_ff[63:32]) * 64'(vm7[31:0]);
      p11_in = 64'(r7_ff[63:32]) * 64'(vm7[63:32]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         cmd8_ff <= tag7_ff.command;
         r8_ff   <= r7_ff;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
      end
   end

   always_comb begin
      full8 = {p11_ff, p00_ff} + {32'h0, p01_ff, 32'h0} + {32'h0, p10_ff, 32'h0};
      case (cmd8_ff)
         rsqs_pkg::CMD_RSQRT32: result9_in = r8_ff;
         rsqs_pkg::CMD_SQRT32:  result9_in = {32'h0, full8[63:32]};
         rsqs_pkg::CMD_RSQRT64: result9_in = r8_ff;
         rsqs_pkg::CMD_SQRT64:  result9_in = full8[127:64];
         default:               result9_in = r8_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         result9_ff <= result9_in;
      end
   end

   assign result_out = result9_ff;

endmodule

`default_nettype wire

/* hw/rtl/fixed_point_rsqrt_and_sqrt.sv */
// Fixed-point reciprocal square root and square root, pipelined.
// Uses rsqs_pkg, rsqs_front, rsqs_newton and rsqs_back.
//
// Usage:
//   req channel: req_command selects 32-bit rsqrt (Q32), 32-bit sqrt,
//   64-bit rsqrt (Q64) or 64-bit sqrt; req_operand_value is the unsigned
//   operand (only bits 31:0 for the 32-bit commands). A beat moves when
//   req_valid and req_ready are both high.
//   rsp channel: rsp_result_value carries one result per request beat, in
//   order, 32-bit results zero-extended.
// Throughput: one beat per cycle when the output is not stalled. Ten register
//   stages (input register, lz count, normalize + seed ROM, x^2, d*x^2,
//   3 - d*x^2, Newton multiply, denormalize, rsqrt*operand partials, final
//   sum/select).
// Stalls: each stage holds its beat while the stage after it is full and
//   cannot move, so bubbles are squeezed out and req_ready stays high until
//   every stage is full.
// Reset: synchronous, active high; clears only the stage valid bits and holds
//   req_ready low, so the pipeline is empty and ready on the first cycle after.
`default_nettype none

module fixed_point_rsqrt_and_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_operand_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_value
);

   localparam int N = rsqs_pkg::STAGE_COUNT;

   logic [N-1:0]      valid_ff;
   logic [N-1:0]      valid_in;
   logic [N-1:0]      stage_ready;

   rsqs_pkg::tag_type front_tag, newton_tag;
   logic [4:0]        front_half, newton_half;
   logic [8:0]        front_seed;
   logic [46:0]       front_dnorm;
   logic [79:0]       newton_prod;

   // a stage may load when it is empty or its own beat moves on
   always_comb begin
      stage_ready[N-1] = !valid_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in = {valid_ff[N-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // no beat is taken while reset is high
   assign req_ready = stage_ready[0] && !reset;
   assign rsp_valid = valid_ff[N-1];

   // stages 0..2: capture, leading-zero count, normalize and seed
   rsqs_front u_front (
      .clock             (clock),
      .stage_en          (stage_ready[2:0]),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .tag_out           (front_tag),
      .half_out          (front_half),
      .seed_out          (front_seed),
      .dnorm_out         (front_dnorm)
   );

   // stages 3..6: Newton refinement
   rsqs_newton u_newton (
      .clock    (clock),
      .stage_en (stage_ready[6:3]),
      .tag_in   (front_tag),
      .half_in  (front_half),
      .seed_in  (front_seed),
      .dnorm_in (front_dnorm),
      .tag_out  (newton_tag),
      .half_out (newton_half),
      .prod_out (newton_prod)
   );

   // stages 7..9: denormalize, square root product, output register
   rsqs_back u_back (
      .clock      (clock),
      .stage_en   (stage_ready[9:7]),
      .tag_in     (newton_tag),
      .half_in    (newton_half),
      .prod_in    (newton_prod),
      .result_out (rsp_result_value)
   );

endmodule

`default_nettype wire
